FILE: rtl/core/ec_point_add_scalar_mult_defines.svh
// Assertion macros used by the checker file of the point arithmetic block.
// Depends on nothing; include by bare file name.
`ifndef EC_POINT_ADD_SCALAR_MULT_DEFINES_SVH
`define EC_POINT_ADD_SCALAR_MULT_DEFINES_SVH

// Clocked check, muted while reset is asserted.
`define ECPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ECPA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/ecpa_pkg.sv
// Shared constants, codes and types of the point arithmetic block.
// Depends on nothing; compile first after the macro header.
package ecpa_pkg;

	localparam int FIELD_WIDTH = 16;
	localparam int CNT_W       = $clog2(FIELD_WIDTH);
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A  = 1'd1;

	localparam logic [FIELD_WIDTH-1:0] MODULUS_RST = FIELD_WIDTH'(23);
	localparam logic [FIELD_WIDTH-1:0] COEF_A_RST  = FIELD_WIDTH'(1);

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_MULT = 1'b1;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2,
		ALU_DIV = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic                   start;
		alu_op_t                op;
		logic [FIELD_WIDTH-1:0] a;
		logic [FIELD_WIDTH-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic                   done;
		logic [FIELD_WIDTH-1:0] q;
		logic [FIELD_WIDTH-1:0] r;
	} alu_rsp_t;

endpackage

FILE: rtl/core/ecpa_if.sv
// Handshake channels of the point arithmetic block: request, result, register write.
// Depends on ecpa_pkg.
interface ecpa_req_if import ecpa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [FIELD_WIDTH-1:0] first_x;
	logic [FIELD_WIDTH-1:0] first_y;
	logic [FIELD_WIDTH-1:0] second_x;
	logic [FIELD_WIDTH-1:0] second_y;
	logic [FIELD_WIDTH-1:0] scalar;
	modport source (output valid, req_type, first_x, first_y, second_x, second_y, scalar,
		input ready);
	modport sink (input valid, req_type, first_x, first_y, second_x, second_y, scalar,
		output ready);
endinterface

interface ecpa_rsp_if import ecpa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [FIELD_WIDTH-1:0] result_x;
	logic [FIELD_WIDTH-1:0] result_y;
	logic                   at_infinity;
	modport source (output valid, result_x, result_y, at_infinity, input ready);
	modport sink (input valid, result_x, result_y, at_infinity, output ready);
endinterface

interface ecpa_cfg_if import ecpa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [FIELD_WIDTH-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ecpa_alu.sv
// Shared modular unit: registered add/sub mod p, bit-serial multiply mod p and divide.
// Depends on ecpa_pkg.
module ecpa_alu import ecpa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [FIELD_WIDTH-1:0] modulus,
	input  alu_req_t               alu_req,
	output alu_rsp_t               alu_rsp
);
	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	alu_op_t                op_q;
	logic [FIELD_WIDTH-1:0] opa_q;
	logic [FIELD_WIDTH-1:0] x_q;
	logic [FIELD_WIDTH-1:0] acc_q;

	logic [FIELD_WIDTH:0] p_ext, sum, sum_red, diff, dbl, dbl_red, mad, mad_red, shl, rem;
	logic                 qbit;
	logic [FIELD_WIDTH-1:0] quick, step;

	always_comb begin
		p_ext   = {1'b0, modulus};
		sum     = {1'b0, alu_req.a} + {1'b0, alu_req.b};
		sum_red = (sum >= p_ext) ? sum - p_ext : sum;
		diff    = (alu_req.a >= alu_req.b) ? {1'b0, alu_req.a} - {1'b0, alu_req.b}
			: {1'b0, alu_req.a} + p_ext - {1'b0, alu_req.b};
		quick   = (alu_req.op == ALU_ADD) ? sum_red[FIELD_WIDTH-1:0] : diff[FIELD_WIDTH-1:0];
		// multiply: double, reduce, conditionally add the multiplicand, reduce
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= p_ext) ? dbl - p_ext : dbl;
		mad     = dbl_red + {1'b0, opa_q};
		mad_red = (mad >= p_ext) ? mad - p_ext : mad;
		// divide: restoring, one quotient bit a cycle
		shl     = {acc_q, x_q[FIELD_WIDTH-1]};
		qbit    = (shl >= {1'b0, opa_q});
		rem     = qbit ? shl - {1'b0, opa_q} : shl;
		if (op_q == ALU_MUL) begin
			step = x_q[FIELD_WIDTH-1] ? mad_red[FIELD_WIDTH-1:0] : dbl_red[FIELD_WIDTH-1:0];
		end else begin
			step = rem[FIELD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (alu_req.start) begin
			busy_q <= (alu_req.op == ALU_MUL) || (alu_req.op == ALU_DIV);
			done_q <= (alu_req.op == ALU_ADD) || (alu_req.op == ALU_SUB);
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(FIELD_WIDTH - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (alu_req.start) begin
			op_q  <= alu_req.op;
			opa_q <= (alu_req.op == ALU_DIV) ? alu_req.b : alu_req.a;
			x_q   <= (alu_req.op == ALU_DIV) ? alu_req.a : alu_req.b;
			acc_q <= ((alu_req.op == ALU_ADD) || (alu_req.op == ALU_SUB)) ? quick : '0;
		end else if (busy_q) begin
			acc_q <= step;
			x_q   <= (op_q == ALU_MUL) ? {x_q[FIELD_WIDTH-2:0], 1'b0}
				: {x_q[FIELD_WIDTH-2:0], qbit};
		end
	end

	assign alu_rsp.done = done_q;
	assign alu_rsp.q    = x_q;
	assign alu_rsp.r    = acc_q;
endmodule

FILE: rtl/core/ec_point_add_scalar_mult.sv
// Top level: affine point addition and scalar multiplication over a prime field.
// Depends on ecpa_pkg, the channel interfaces and ecpa_alu.
//
//   channel | dir | role
//   --------+-----+------------------------------------------------------
//   req     | in  | request: req_type, two points, scalar
//   rsp     | out | result point and infinity flag, held until taken
//   cfg     | in  | register write: modulus, coef_a (always ready)
//
// Every field operation runs on the one shared unit. A point addition or doubling
// inverts its denominator by extended Euclid, with a divide, a multiply and a
// subtract per quotient step, unless the result is already known to be infinity.
// A multiplication by k chains up to k-1 additions; the block takes no request until
// its result is latched, and a result waiting on rsp stalls only the final step.
// Reset: modulus 23, coef_a 1, sequencer idle, no result pending.
module ec_point_add_scalar_mult import ecpa_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	ecpa_req_if.sink     req,
	ecpa_rsp_if.source   rsp,
	ecpa_cfg_if.sink     cfg
);
	localparam int NS = 29;

	typedef enum logic [NS-1:0] {
		S_IDLE   = NS'(1) << 0,
		S_RED_A  = NS'(1) << 1,
		S_RED_GX = NS'(1) << 2,
		S_RED_GY = NS'(1) << 3,
		S_RED_HX = NS'(1) << 4,
		S_RED_HY = NS'(1) << 5,
		S_SETUP  = NS'(1) << 6,
		S_ML_CHK = NS'(1) << 7,
		S_PA_CHK = NS'(1) << 8,
		S_DB_SQ  = NS'(1) << 9,
		S_DB_2   = NS'(1) << 10,
		S_DB_3   = NS'(1) << 11,
		S_DB_A   = NS'(1) << 12,
		S_DB_DEN = NS'(1) << 13,
		S_AD_DX  = NS'(1) << 14,
		S_AD_DY  = NS'(1) << 15,
		S_IV_DIV = NS'(1) << 16,
		S_IV_MUL = NS'(1) << 17,
		S_IV_SUB = NS'(1) << 18,
		S_IV_END = NS'(1) << 19,
		S_SL_MUL = NS'(1) << 20,
		S_X_SQ   = NS'(1) << 21,
		S_X_S1   = NS'(1) << 22,
		S_X_S2   = NS'(1) << 23,
		S_Y_S1   = NS'(1) << 24,
		S_Y_MUL  = NS'(1) << 25,
		S_Y_S2   = NS'(1) << 26,
		S_PA_END = NS'(1) << 27,
		S_FIN    = NS'(1) << 28
	} state_t;

	state_t state_q;
	logic   issued_q;
	logic   out_valid_q;

	logic [FIELD_WIDTH-1:0] modulus_q, coef_q;
	logic                   typ_q;
	logic [FIELD_WIDTH-1:0] k_q, i_q;
	logic [FIELD_WIDTH-1:0] gx_q, gy_q, hx_q, hy_q, ux_q, uy_q, a_red_q;
	logic                   uinf_q;
	logic [FIELD_WIDTH-1:0] t_q, num_q, den_q, s_q, rx_q, m_q, qt_q;
	logic [FIELD_WIDTH-1:0] r0_q, r1_q, s0_q, s1_q, tr_q;
	logic [FIELD_WIDTH-1:0] out_x_q, out_y_q;
	logic                   out_inf_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic     arith;

	ecpa_alu u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (modulus_q),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);

	// operand select for the shared unit
	always_comb begin
		arith     = 1'b1;
		alu_req.op = ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		unique case (state_q)
			S_RED_A:  begin alu_req.op = ALU_DIV; alu_req.a = coef_q; alu_req.b = modulus_q; end
			S_RED_GX: begin alu_req.op = ALU_DIV; alu_req.a = gx_q;   alu_req.b = modulus_q; end
			S_RED_GY: begin alu_req.op = ALU_DIV; alu_req.a = gy_q;   alu_req.b = modulus_q; end
			S_RED_HX: begin alu_req.op = ALU_DIV; alu_req.a = hx_q;   alu_req.b = modulus_q; end
			S_RED_HY: begin alu_req.op = ALU_DIV; alu_req.a = hy_q;   alu_req.b = modulus_q; end
			S_DB_SQ:  begin alu_req.op = ALU_MUL; alu_req.a = ux_q;   alu_req.b = ux_q; end
			S_DB_2:   begin alu_req.op = ALU_ADD; alu_req.a = t_q;    alu_req.b = t_q; end
			S_DB_3:   begin alu_req.op = ALU_ADD; alu_req.a = num_q;  alu_req.b = t_q; end
			S_DB_A:   begin alu_req.op = ALU_ADD; alu_req.a = num_q;  alu_req.b = a_red_q; end
			S_DB_DEN: begin alu_req.op = ALU_ADD; alu_req.a = uy_q;   alu_req.b = uy_q; end
			S_AD_DX:  begin alu_req.op = ALU_SUB; alu_req.a = hx_q;   alu_req.b = ux_q; end
			S_AD_DY:  begin alu_req.op = ALU_SUB; alu_req.a = hy_q;   alu_req.b = uy_q; end
			S_IV_DIV: begin
				alu_req.op = ALU_DIV; alu_req.a = r0_q; alu_req.b = r1_q;
				arith = (r1_q != '0);
			end
			S_IV_MUL: begin alu_req.op = ALU_MUL; alu_req.a = s1_q;   alu_req.b = qt_q; end
			S_IV_SUB: begin alu_req.op = ALU_SUB; alu_req.a = s0_q;   alu_req.b = m_q; end
			S_SL_MUL: begin alu_req.op = ALU_MUL; alu_req.a = num_q;  alu_req.b = den_q; end
			S_X_SQ:   begin alu_req.op = ALU_MUL; alu_req.a = s_q;    alu_req.b = s_q; end
			S_X_S1:   begin alu_req.op = ALU_SUB; alu_req.a = t_q;    alu_req.b = ux_q; end
			S_X_S2:   begin alu_req.op = ALU_SUB; alu_req.a = t_q;    alu_req.b = hx_q; end
			S_Y_S1:   begin alu_req.op = ALU_SUB; alu_req.a = ux_q;   alu_req.b = rx_q; end
			S_Y_MUL:  begin alu_req.op = ALU_MUL; alu_req.a = s_q;    alu_req.b = t_q; end
			S_Y_S2:   begin alu_req.op = ALU_SUB; alu_req.a = t_q;    alu_req.b = uy_q; end
			default:  arith = 1'b0;
		endcase
		alu_req.start = arith && !issued_q;
	end

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
			coef_q    <= COEF_A_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MODULUS: modulus_q <= cfg.data;
				CFG_COEF_A:  coef_q    <= cfg.data;
				default:     ;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (alu_req.start) begin
				issued_q <= 1'b1;
			end else if (alu_rsp.done) begin
				issued_q <= 1'b0;
			end
			// load a new result once the previous one has gone, else drop it when taken
			if ((state_q == S_FIN) && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						// no field below 2: straight to an infinity result
						state_q <= (modulus_q < FIELD_WIDTH'(2)) ? S_FIN : S_RED_A;
					end
				end
				S_RED_A:  if (alu_rsp.done) state_q <= S_RED_GX;
				S_RED_GX: if (alu_rsp.done) state_q <= S_RED_GY;
				S_RED_GY: if (alu_rsp.done) state_q <= S_RED_HX;
				S_RED_HX: if (alu_rsp.done) state_q <= S_RED_HY;
				S_RED_HY: if (alu_rsp.done) state_q <= S_SETUP;
				S_SETUP:  state_q <= (typ_q == REQ_ADD) ? S_PA_CHK : S_ML_CHK;
				S_ML_CHK: begin
					if (i_q >= k_q) begin
						state_q <= S_FIN;
					end else if (!uinf_q) begin
						state_q <= S_PA_CHK;
					end
				end
				S_PA_CHK: begin
					if ((ux_q == hx_q) && (uy_q == hy_q)) begin
						state_q <= (uy_q == '0) ? S_PA_END : S_DB_SQ;
					end else begin
						state_q <= S_AD_DX;
					end
				end
				S_DB_SQ:  if (alu_rsp.done) state_q <= S_DB_2;
				S_DB_2:   if (alu_rsp.done) state_q <= S_DB_3;
				S_DB_3:   if (alu_rsp.done) state_q <= S_DB_A;
				S_DB_A:   if (alu_rsp.done) state_q <= S_DB_DEN;
				S_DB_DEN: if (alu_rsp.done) state_q <= S_IV_DIV;
				S_AD_DX: begin
					if (alu_rsp.done) begin
						state_q <= (alu_rsp.r == '0) ? S_PA_END : S_AD_DY;
					end
				end
				S_AD_DY:  if (alu_rsp.done) state_q <= S_IV_DIV;
				S_IV_DIV: begin
					if (r1_q == '0) begin
						state_q <= S_IV_END;
					end else if (alu_rsp.done) begin
						state_q <= S_IV_MUL;
					end
				end
				S_IV_MUL: if (alu_rsp.done) state_q <= S_IV_SUB;
				S_IV_SUB: if (alu_rsp.done) state_q <= S_IV_DIV;
				S_IV_END: state_q <= S_SL_MUL;
				S_SL_MUL: if (alu_rsp.done) state_q <= S_X_SQ;
				S_X_SQ:   if (alu_rsp.done) state_q <= S_X_S1;
				S_X_S1:   if (alu_rsp.done) state_q <= S_X_S2;
				S_X_S2:   if (alu_rsp.done) state_q <= S_Y_S1;
				S_Y_S1:   if (alu_rsp.done) state_q <= S_Y_MUL;
				S_Y_MUL:  if (alu_rsp.done) state_q <= S_Y_S2;
				S_Y_S2:   if (alu_rsp.done) state_q <= S_PA_END;
				S_PA_END: state_q <= (typ_q == REQ_ADD) ? S_FIN : S_ML_CHK;
				S_FIN: begin
					// hold until the previous result has gone
					if (!out_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				typ_q  <= req.req_type;
				gx_q   <= req.first_x;
				gy_q   <= req.first_y;
				hx_q   <= req.second_x;
				hy_q   <= req.second_y;
				k_q    <= req.scalar;
				uinf_q <= 1'b1;
			end
			S_RED_A:  if (alu_rsp.done) a_red_q <= alu_rsp.r;
			S_RED_GX: if (alu_rsp.done) gx_q <= alu_rsp.r;
			S_RED_GY: if (alu_rsp.done) gy_q <= alu_rsp.r;
			S_RED_HX: if (alu_rsp.done) hx_q <= alu_rsp.r;
			S_RED_HY: if (alu_rsp.done) hy_q <= alu_rsp.r;
			S_SETUP: begin
				ux_q   <= gx_q;
				uy_q   <= gy_q;
				uinf_q <= 1'b0;
				i_q    <= FIELD_WIDTH'(1);
				// multiplication always adds the base point
				if (typ_q == REQ_MULT) begin
					hx_q <= gx_q;
					hy_q <= gy_q;
				end
			end
			S_ML_CHK: begin
				if (i_q < k_q) begin
					i_q <= i_q + 1'b1;
					// infinity acts as identity: restart from the base point
					if (uinf_q) begin
						ux_q   <= gx_q;
						uy_q   <= gy_q;
						uinf_q <= 1'b0;
					end
				end
			end
			S_PA_CHK: begin
				if ((ux_q == hx_q) && (uy_q == hy_q) && (uy_q == '0)) begin
					uinf_q <= 1'b1;
				end
			end
			S_DB_SQ:  if (alu_rsp.done) t_q <= alu_rsp.r;
			S_DB_2:   if (alu_rsp.done) num_q <= alu_rsp.r;
			S_DB_3:   if (alu_rsp.done) num_q <= alu_rsp.r;
			S_DB_A:   if (alu_rsp.done) num_q <= alu_rsp.r;
			S_DB_DEN: begin
				if (alu_rsp.done) begin
					r0_q <= alu_rsp.r;
					r1_q <= modulus_q;
					s0_q <= FIELD_WIDTH'(1);
					s1_q <= '0;
				end
			end
			S_AD_DX: begin
				if (alu_rsp.done) begin
					den_q <= alu_rsp.r;
					if (alu_rsp.r == '0) begin
						uinf_q <= 1'b1;
					end
				end
			end
			S_AD_DY: begin
				if (alu_rsp.done) begin
					num_q <= alu_rsp.r;
					r0_q  <= den_q;
					r1_q  <= modulus_q;
					s0_q  <= FIELD_WIDTH'(1);
					s1_q  <= '0;
				end
			end
			S_IV_DIV: begin
				if (alu_rsp.done) begin
					qt_q <= alu_rsp.q;
					tr_q <= alu_rsp.r;
				end
			end
			S_IV_MUL: if (alu_rsp.done) m_q <= alu_rsp.r;
			S_IV_SUB: begin
				if (alu_rsp.done) begin
					r0_q <= r1_q;
					r1_q <= tr_q;
					s0_q <= s1_q;
					s1_q <= alu_rsp.r;
				end
			end
			// no inverse when the gcd is not one: slope drops to zero
			S_IV_END: den_q <= (r0_q == FIELD_WIDTH'(1)) ? s0_q : '0;
			S_SL_MUL: if (alu_rsp.done) s_q <= alu_rsp.r;
			S_X_SQ:   if (alu_rsp.done) t_q <= alu_rsp.r;
			S_X_S1:   if (alu_rsp.done) t_q <= alu_rsp.r;
			S_X_S2:   if (alu_rsp.done) rx_q <= alu_rsp.r;
			S_Y_S1:   if (alu_rsp.done) t_q <= alu_rsp.r;
			S_Y_MUL:  if (alu_rsp.done) t_q <= alu_rsp.r;
			S_Y_S2: begin
				if (alu_rsp.done) begin
					ux_q   <= rx_q;
					uy_q   <= alu_rsp.r;
					uinf_q <= 1'b0;
				end
			end
			S_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					out_x_q   <= uinf_q ? '0 : ux_q;
					out_y_q   <= uinf_q ? '0 : uy_q;
					out_inf_q <= uinf_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_x    = out_x_q;
	assign rsp.result_y    = out_y_q;
	assign rsp.at_infinity = out_inf_q;
endmodule

FILE: rtl/core/ecpa_checker.sv
// Port-level checks on the point arithmetic block, bound to the top level.
// Depends on ecpa_pkg and ec_point_add_scalar_mult_defines.svh.
`include "ec_point_add_scalar_mult_defines.svh"

module ecpa_checker import ecpa_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [FIELD_WIDTH-1:0] result_x,
	input logic [FIELD_WIDTH-1:0] result_y,
	input logic                   at_infinity,
	input logic                   cfg_ready
);
	// a transaction starts a multi-cycle job: no back-to-back acceptance
	`ECPA_ASSERT(a_busy_after_req, (req_valid && req_ready) |=> !req_ready,
		"request accepted while busy")
	`ECPA_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid,
		"result dropped before taken")
	`ECPA_ASSERT_ALWAYS(a_inf_zero, (rsp_valid && at_infinity) |-> (result_x == '0 && result_y == '0),
		"infinity result with nonzero coordinates")
	`ECPA_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "register port stalled")
endmodule

bind ec_point_add_scalar_mult ecpa_checker u_ecpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.result_x    (rsp.result_x),
	.result_y    (rsp.result_y),
	.at_infinity (rsp.at_infinity),
	.cfg_ready   (cfg.ready)
);

FILE: sim/tb_top.sv
// Self-checking bench for ec_point_add_scalar_mult: point sums and scalar multiples.
// Depends on ecpa_pkg, the channel interfaces and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
	import ecpa_pkg::*;

	localparam int  RESET_CYCLES = 7;
	localparam int  DRAIN_CYCLES = 40;
	// Upper bound on the length of the whole run, in cycles.
	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam int  LONG_HOLD = 3000;

	typedef struct packed {
		logic                   req_type;
		logic [FIELD_WIDTH-1:0] fx;
		logic [FIELD_WIDTH-1:0] fy;
		logic [FIELD_WIDTH-1:0] sx;
		logic [FIELD_WIDTH-1:0] sy;
		logic [FIELD_WIDTH-1:0] k;
	} point_req_t;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] x;
		logic [FIELD_WIDTH-1:0] y;
		logic                   inf;
	} curve_pt_t;

	logic clk;
	logic arst_n;

	ecpa_req_if req_ch ();
	ecpa_rsp_if rsp_ch ();
	ecpa_cfg_if cfg_ch ();

	ec_point_add_scalar_mult dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copies of the two registers.
	logic [FIELD_WIDTH-1:0] mdl_modulus;
	logic [FIELD_WIDTH-1:0] mdl_coef_a;

	curve_pt_t pending_points[$];
	int        fail_count;
	int        sent_count;
	int        checked_count;
	int        mult_count;
	int        inf_count;
	longint    cycle_count;
	int        burst_left;
	bit        hold_go;
	int        hold_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_points.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor of the curve arithmetic, all sums in 64-bit integers.
	// ------------------------------------------------------------------
	function automatic longint unsigned mod_minus(longint unsigned u, longint unsigned v,
			longint unsigned p);
		return (u + p - v) % p;
	endfunction

	// Extended Euclid; zero when v has no inverse modulo p.
	function automatic longint unsigned mod_inverse(longint unsigned v, longint unsigned p);
		longint r0, r1, s0, s1, q, tr, ts;
		r0 = longint'(v % p);
		r1 = longint'(p);
		s0 = 1;
		s1 = 0;
		while (r1 != 0) begin
			q  = r0 / r1;
			tr = r0 - q * r1;
			ts = s0 - q * s1;
			r0 = r1;
			r1 = tr;
			s0 = s1;
			s1 = ts;
		end
		if (r0 != 1)
			return 0;
		s0 = s0 % longint'(p);
		if (s0 < 0)
			s0 += longint'(p);
		return longint'(s0);
	endfunction

	function automatic curve_pt_t point_sum(curve_pt_t u, curve_pt_t v, longint unsigned a,
			longint unsigned p);
		curve_pt_t r;
		longint unsigned s, num, den, dx, dy, ux, uy, vx, vy, rx;
		r = '{x: '0, y: '0, inf: 1'b1};
		ux = u.x;
		uy = u.y;
		vx = v.x;
		vy = v.y;
		if (ux == vx && uy == vy) begin
			// Doubling; a point on the x axis doubles to infinity.
			if (uy == 0)
				return r;
			num = ((3 * ((ux * ux) % p)) % p + a) % p;
			den = (2 * uy) % p;
			s   = (num * mod_inverse(den, p)) % p;
		end else begin
			dx = mod_minus(vx, ux, p);
			dy = mod_minus(vy, uy, p);
			if (dx == 0)
				return r;
			s = (dy * mod_inverse(dx, p)) % p;
		end
		rx    = mod_minus(mod_minus((s * s) % p, ux, p), vx, p);
		r.x   = FIELD_WIDTH'(rx);
		r.y   = FIELD_WIDTH'(mod_minus((s * mod_minus(ux, rx, p)) % p, uy, p));
		r.inf = 1'b0;
		return r;
	endfunction

	function automatic curve_pt_t predict_point(point_req_t rq);
		longint unsigned p, a;
		curve_pt_t g, h, acc;
		int unsigned i;
		acc = '{x: '0, y: '0, inf: 1'b1};
		p   = mdl_modulus;
		if (p < 2)
			return acc;
		a   = mdl_coef_a % p;
		g.x = FIELD_WIDTH'(rq.fx % p);
		g.y = FIELD_WIDTH'(rq.fy % p);
		g.inf = 1'b0;
		if (rq.req_type == REQ_ADD) begin
			h.x = FIELD_WIDTH'(rq.sx % p);
			h.y = FIELD_WIDTH'(rq.sy % p);
			h.inf = 1'b0;
			acc = point_sum(g, h, a, p);
		end else begin
			acc = g;
			for (i = 1; i < rq.k; i++) begin
				// Infinity on the way acts as the identity.
				if (acc.inf)
					acc = g;
				else
					acc = point_sum(acc, g, a, p);
			end
		end
		if (acc.inf) begin
			acc.x = '0;
			acc.y = '0;
		end
		return acc;
	endfunction

	// ------------------------------------------------------------------
	// Result side: stall pattern, long hold-off and the checker.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go && hold_left == 0) begin
			hold_left <= LONG_HOLD;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	int unsigned stall_mode;
	int unsigned stall_phase;

	always @(posedge clk) begin
		curve_pt_t exp_pt;
		if (rsp_ch.valid && rsp_ch.ready && arst_n) begin
			checked_count++;
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d inf=%0b", $time,
					rsp_ch.result_x, rsp_ch.result_y, rsp_ch.at_infinity);
				fail_count++;
			end else begin
				exp_pt = pending_points.pop_front();
				if (rsp_ch.result_x !== exp_pt.x) begin
					$display("%0t: result_x expected %0d actual %0d", $time,
						exp_pt.x, rsp_ch.result_x);
					fail_count++;
				end
				if (rsp_ch.result_y !== exp_pt.y) begin
					$display("%0t: result_y expected %0d actual %0d", $time,
						exp_pt.y, rsp_ch.result_y);
					fail_count++;
				end
				if (rsp_ch.at_infinity !== exp_pt.inf) begin
					$display("%0t: at_infinity expected %0b actual %0b", $time,
						exp_pt.inf, rsp_ch.at_infinity);
					fail_count++;
				end
				if (exp_pt.inf)
					inf_count++;
			end
		end
		// Pick a new stall mode periodically: free-running, random or sparse.
		stall_phase++;
		if (stall_phase % 64 == 0)
			stall_mode = $urandom_range(0, 2);
		if (hold_left > 0 || hold_go)
			rsp_ch.ready <= 1'b0;
		else if (stall_mode == 0)
			rsp_ch.ready <= 1'b1;
		else if (stall_mode == 1)
			rsp_ch.ready <= $urandom_range(0, 1);
		else
			rsp_ch.ready <= (stall_phase % 4 == 0);
	end

	// ------------------------------------------------------------------
	// Request and register side.
	// ------------------------------------------------------------------

	// Offer one transaction, hold it until taken, then maybe drop valid for a gap.
	task automatic send_point_req(point_req_t rq);
		int gap;
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= rq.req_type;
		req_ch.first_x  <= rq.fx;
		req_ch.first_y  <= rq.fy;
		req_ch.second_x <= rq.sx;
		req_ch.second_y <= rq.sy;
		req_ch.scalar   <= rq.k;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_points.push_back(predict_point(rq));
		sent_count++;
		if (rq.req_type == REQ_MULT)
			mult_count++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 8);
			gap = $urandom_range(1, 15);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_WIDTH-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_MODULUS)
			mdl_modulus = val;
		else
			mdl_coef_a = val;
		@(posedge clk);
	endtask

	// Wait for every result, then let the block settle before any register write.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_curve(logic [FIELD_WIDTH-1:0] p, logic [FIELD_WIDTH-1:0] a);
		drain_results();
		write_reg(CFG_MODULUS, p);
		write_reg(CFG_COEF_A, a);
	endtask

	function automatic point_req_t make_req(logic t, int fx, int fy, int sx, int sy, int k);
		point_req_t rq;
		rq.req_type = t;
		rq.fx = FIELD_WIDTH'(fx);
		rq.fy = FIELD_WIDTH'(fy);
		rq.sx = FIELD_WIDTH'(sx);
		rq.sy = FIELD_WIDTH'(sy);
		rq.k  = FIELD_WIDTH'(k);
		return rq;
	endfunction

	// Mostly reduced coordinates; now and then a raw 16-bit value that may lie above p.
	function automatic logic [FIELD_WIDTH-1:0] pick_coord();
		if (mdl_modulus < 2 || $urandom_range(0, 7) == 0)
			return FIELD_WIDTH'($urandom);
		return FIELD_WIDTH'($urandom % mdl_modulus);
	endfunction

	function automatic point_req_t random_req(int unsigned max_k, bit wide_k);
		point_req_t rq;
		int unsigned pick;
		logic [FIELD_WIDTH-1:0] p;
		p = mdl_modulus;
		rq.req_type = $urandom_range(0, 1);
		rq.fx = pick_coord();
		rq.fy = pick_coord();
		rq.sx = pick_coord();
		rq.sy = pick_coord();
		rq.k  = wide_k ? FIELD_WIDTH'($urandom) : FIELD_WIDTH'($urandom_range(0, max_k));
		pick  = $urandom_range(0, 7);
		if (rq.req_type == REQ_ADD && p >= 2) begin
			// Steer towards doubling, vertical lines and points on the x axis.
			if (pick < 2) begin
				rq.sx = rq.fx;
				rq.sy = rq.fy;
			end else if (pick == 2) begin
				rq.sx = rq.fx;
				rq.sy = FIELD_WIDTH'((p - rq.fy % p) % p);
			end else if (pick == 3) begin
				rq.fy = '0;
				rq.sx = rq.fx;
				rq.sy = '0;
			end
		end else if (rq.req_type == REQ_MULT && pick == 0) begin
			rq.fy = '0;
		end
		return rq;
	endfunction

	task automatic random_burst(int n, int unsigned max_k, bit wide_k);
		repeat (n) send_point_req(random_req(max_k, wide_k));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Special cases on the reset curve, p = 23, a = 1.
	task automatic test_directed();
		send_point_req(make_req(REQ_ADD, 3, 10, 9, 7, 0));
		send_point_req(make_req(REQ_ADD, 3, 10, 3, 10, 0));        // doubling
		send_point_req(make_req(REQ_ADD, 4, 0, 4, 0, 0));          // doubling on x axis
		send_point_req(make_req(REQ_ADD, 3, 10, 3, 13, 0));        // vertical line
		send_point_req(make_req(REQ_ADD, 0, 0, 0, 0, 0));
		send_point_req(make_req(REQ_ADD, 65535, 65535, 65535, 65535, 0));
		send_point_req(make_req(REQ_ADD, 65535, 0, 26, 65535, 0)); // reduce above p
		send_point_req(make_req(REQ_ADD, 26, 33, 3, 10, 0));       // same point after reduction
		send_point_req(make_req(REQ_MULT, 3, 10, 0, 0, 0));
		send_point_req(make_req(REQ_MULT, 3, 10, 0, 0, 1));
		send_point_req(make_req(REQ_MULT, 3, 10, 0, 0, 2));
		send_point_req(make_req(REQ_MULT, 3, 10, 0, 0, 7));
		send_point_req(make_req(REQ_MULT, 4, 0, 65535, 65535, 3)); // infinity mid-chain
		send_point_req(make_req(REQ_MULT, 65535, 65535, 65535, 65535, 5));
		send_point_req(make_req(REQ_MULT, 0, 1, 0, 0, 28));
	endtask

	// Non-prime modulus: denominators without an inverse give slope 0.
	task automatic test_no_inverse();
		set_curve(16'd15, 16'd7);
		send_point_req(make_req(REQ_ADD, 1, 2, 4, 9, 0));          // dx = 3
		send_point_req(make_req(REQ_ADD, 2, 5, 2, 5, 0));          // 2y = 10
		send_point_req(make_req(REQ_MULT, 1, 3, 0, 0, 6));
		random_burst(35, 10, 1'b0);
	endtask

	// No field at all: every result is infinity, so wide scalars are cheap here.
	task automatic test_no_field();
		set_curve(16'd0, 16'd65535);
		send_point_req(make_req(REQ_MULT, 5, 5, 0, 0, 65535));
		random_burst(20, 0, 1'b1);
		set_curve(16'd1, 16'd0);
		send_point_req(make_req(REQ_ADD, 65535, 65535, 0, 0, 32768));
		random_burst(20, 0, 1'b1);
	endtask

	// Hold the result side off while requests keep coming, so the input backs up.
	task automatic test_backpressure();
		set_curve(16'd97, 16'd2);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		random_burst(12, 6, 1'b0);
	endtask

	task automatic test_random_curves();
		set_curve(MODULUS_RST, COEF_A_RST);
		random_burst(50, 12, 1'b0);
		set_curve(16'd65521, 16'd65535);
		random_burst(45, 8, 1'b0);
		set_curve(16'd65535, 16'd65535);
		random_burst(15, 6, 1'b0);
		set_curve(16'd3, 16'd0);
		random_burst(30, 40, 1'b0);
		set_curve(16'd97, 16'd2);
		random_burst(40, 12, 1'b0);
		set_curve(16'd7919, 16'd3);
		random_burst(30, 10, 1'b0);
	endtask

	initial begin
		fail_count    = 0;
		sent_count    = 0;
		checked_count = 0;
		mult_count    = 0;
		inf_count     = 0;
		cycle_count   = 0;
		burst_left    = 0;
		stall_mode    = 0;
		stall_phase   = 0;
		mdl_modulus   = MODULUS_RST;
		mdl_coef_a    = COEF_A_RST;
		arst_n          <= 1'b0;
		hold_go         <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_ADD;
		req_ch.first_x  <= '0;
		req_ch.first_y  <= '0;
		req_ch.second_x <= '0;
		req_ch.second_y <= '0;
		req_ch.scalar   <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= CFG_MODULUS;
		cfg_ch.data     <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_backpressure();
		test_no_inverse();
		test_no_field();
		test_random_curves();
		drain_results();

		$display("Sent %0d requests (%0d scalar multiples), checked %0d results, %0d at infinity",
			sent_count, mult_count, checked_count, inf_count);
		$display("Curves covered prime, composite, maximal and empty moduli in %0d cycles",
			cycle_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
